FILE: hw/rtl/pst_pkg.sv
// Shared types and constants for the process state table.
package pst_pkg;

	localparam int DEPTH_DEF      = 32;
	localparam int ID_BITS_DEF    = 16;
	localparam int STATE_BITS_DEF = 8;
	localparam int WAITING_RESET  = 1;

	localparam int MODE_W   = 3;
	localparam int STATUS_W = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 3'd0,
		MODE_DELETE = 3'd1,
		MODE_GET    = 3'd2,
		MODE_LIST   = 3'd3,
		MODE_UPDATE = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DELETED  = 3'd0,
		STAT_STATE    = 3'd1,
		STAT_WAIT_ID  = 3'd2,
		STAT_NOTFOUND = 3'd3,
		STAT_FULL     = 3'd4
	} status_t;

endpackage

FILE: hw/rtl/process_state_table_top.sv
// Process state table: sequencer around the entry memory.
//
//  port group    dir  carries
//  s_*           in   tuser: mode; tdata: process_id, state_code
//  m_*           out  tuser: status; tdata: result_id, result_state; tlast: last
//  cfg_*         in   waiting_code write
//
// Insert writes the new entry at the tail from idle; a full table answers full. Other
// operations scan the memory newest to oldest behind a registered read, at one entry per
// cycle unless a listing stall holds the scan; a delete that moves entries shifts the newer
// ones down a place and restarts the read. The single memory port pair sets this rate.
// Reset empties the table and sets waiting_code to 1; no clearing pass is needed.
// A stalled output holds the listing scan until the pending id is taken.
module process_state_table_top
	import pst_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int ID_BITS    = ID_BITS_DEF,
	parameter int STATE_BITS = STATE_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	// mode
	input  logic [MODE_W-1:0]                           s_tuser,
	// process_id, state_code
	input  logic [((ID_BITS+STATE_BITS+7)/8)*8-1:0]     s_tdata,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	// status
	output logic [STATUS_W-1:0]                         m_tuser,
	// result_id, result_state
	output logic [((ID_BITS+STATE_BITS+7)/8)*8-1:0]     m_tdata,
	output logic                                        m_tlast,
	input  logic                                        cfg_we,
	input  logic [STATE_BITS-1:0]                       cfg_wdata
);

	localparam int ENT_W  = ID_BITS + STATE_BITS;
	localparam int DATA_W = ((ENT_W + 7) / 8) * 8;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_FINISH
	} fsm_t;

	fsm_t                  state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [STATE_BITS-1:0] waiting_q;
	mode_t                 op_q;
	logic [ID_BITS-1:0]    pid_q;
	logic [STATE_BITS-1:0] st_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic                  issue_q;
	logic                  valid_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  pend_valid_q;
	logic [ID_BITS-1:0]    pend_id_q;
	status_t               res_status_q;
	logic [ID_BITS-1:0]    res_id_q;
	logic [STATE_BITS-1:0] res_state_q;
	logic                  m_tvalid_q;
	status_t               out_status_q;
	logic [ID_BITS-1:0]    out_id_q;
	logic [STATE_BITS-1:0] out_state_q;
	logic                  out_last_q;

	logic [ENT_W-1:0]      rd_data;
	logic [ID_BITS-1:0]    ent_id;
	logic [STATE_BITS-1:0] ent_state;
	logic [ID_BITS-1:0]    in_id;
	logic [STATE_BITS-1:0] in_state;
	logic [IDX_W-1:0]      last_idx;
	logic                  full;
	logic                  empty;
	logic                  out_free;
	logic                  id_hit;
	logic                  wait_hit;
	logic                  scan_end;
	logic                  list_stall;
	logic                  rd_en;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_wa;
	logic [ENT_W-1:0]      mem_wd;

	assign in_id     = s_tdata[ID_BITS-1:0];
	assign in_state  = s_tdata[ENT_W-1:ID_BITS];
	assign ent_id    = rd_data[ENT_W-1:STATE_BITS];
	assign ent_state = rd_data[STATE_BITS-1:0];
	assign last_idx  = IDX_W'(cnt_q - CNT_W'(1));
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign out_free  = !m_tvalid_q || m_tready;
	assign id_hit    = (ent_id == pid_q);
	assign wait_hit  = (ent_state == waiting_q);
	assign scan_end  = (idx_s1 == '0);

	assign list_stall = (state_q == ST_SCAN) && (op_q == MODE_LIST) && valid_s1 && wait_hit
		&& pend_valid_q && !out_free;
	assign rd_en = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && issue_q && !list_stall;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = DATA_W'({out_state_q, out_id_q});
	assign m_tlast  = out_last_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_s1;
		mem_wd = rd_data;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && (mode_t'(s_tuser) == MODE_INSERT) && !full) begin
					mem_we = 1'b1;
					mem_wa = IDX_W'(cnt_q);
					mem_wd = {in_id, in_state};
				end
			end
			ST_SCAN: begin
				if (valid_s1 && (op_q == MODE_UPDATE) && id_hit) begin
					mem_we = 1'b1;
					mem_wd = {pid_q, st_q};
				end
			end
			ST_SHIFT: begin
				if (valid_s1) begin
					mem_we = 1'b1;
					mem_wa = IDX_W'(idx_s1 - IDX_W'(1));
				end
			end
			default: ;
		endcase
	end

	pst_ram #(
		.DEPTH  (DEPTH),
		.WIDTH  (ENT_W),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.wa      (mem_wa),
		.wd      (mem_wd),
		.rd_en   (rd_en),
		.ra      (rd_idx_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			waiting_q    <= STATE_BITS'(WAITING_RESET);
			m_tvalid_q   <= 1'b0;
			valid_s1     <= 1'b0;
			issue_q      <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				waiting_q <= cfg_wdata;
			end
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			// advance the read pipeline
			if (rd_en) begin
				valid_s1 <= 1'b1;
				idx_s1   <= rd_idx_q;
				if (state_q == ST_SCAN) begin
					if (rd_idx_q == '0) begin
						issue_q <= 1'b0;
					end else begin
						rd_idx_q <= rd_idx_q - IDX_W'(1);
					end
				end else begin
					if (rd_idx_q == last_idx) begin
						issue_q <= 1'b0;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
			end else if (!list_stall) begin
				valid_s1 <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q         <= mode_t'(s_tuser);
						pid_q        <= in_id;
						st_q         <= in_state;
						pend_valid_q <= 1'b0;
						valid_s1     <= 1'b0;
						rd_idx_q     <= last_idx;
						res_id_q     <= '0;
						res_state_q  <= '0;
						case (mode_t'(s_tuser))
							MODE_INSERT: begin
								if (full) begin
									res_status_q <= STAT_FULL;
									state_q      <= ST_FINISH;
								end else begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							MODE_DELETE, MODE_GET, MODE_LIST: begin
								if (empty) begin
									res_status_q <= STAT_NOTFOUND;
									state_q      <= ST_FINISH;
								end else begin
									issue_q <= 1'b1;
									state_q <= ST_SCAN;
								end
							end
							MODE_UPDATE: begin
								if (!empty) begin
									issue_q <= 1'b1;
									state_q <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (valid_s1) begin
						if (op_q == MODE_LIST) begin
							if (!list_stall) begin
								if (wait_hit) begin
									if (pend_valid_q) begin
										m_tvalid_q   <= 1'b1;
										out_status_q <= STAT_WAIT_ID;
										out_id_q     <= pend_id_q;
										out_state_q  <= '0;
										out_last_q   <= 1'b0;
									end
									pend_id_q    <= ent_id;
									pend_valid_q <= 1'b1;
								end
								if (scan_end) begin
									if (wait_hit || pend_valid_q) begin
										res_status_q <= STAT_WAIT_ID;
										res_id_q     <= wait_hit ? ent_id : pend_id_q;
									end else begin
										res_status_q <= STAT_NOTFOUND;
									end
									state_q <= ST_FINISH;
								end
							end
						end else if (id_hit) begin
							issue_q <= 1'b0;
							case (op_q)
								MODE_GET: begin
									res_status_q <= STAT_STATE;
									res_state_q  <= ent_state;
									state_q      <= ST_FINISH;
								end
								MODE_DELETE: begin
									if (idx_s1 == last_idx) begin
										cnt_q        <= cnt_q - CNT_W'(1);
										res_status_q <= STAT_DELETED;
										res_id_q     <= pid_q;
										state_q      <= ST_FINISH;
									end else begin
										rd_idx_q <= idx_s1 + IDX_W'(1);
										issue_q  <= 1'b1;
										valid_s1 <= 1'b0;
										state_q  <= ST_SHIFT;
									end
								end
								default: begin
									state_q <= ST_IDLE;
								end
							endcase
						end else if (scan_end) begin
							if (op_q == MODE_UPDATE) begin
								state_q <= ST_IDLE;
							end else begin
								res_status_q <= STAT_NOTFOUND;
								state_q      <= ST_FINISH;
							end
						end
					end
				end
				ST_SHIFT: begin
					if (valid_s1 && (idx_s1 == last_idx)) begin
						issue_q      <= 1'b0;
						cnt_q        <= cnt_q - CNT_W'(1);
						res_status_q <= STAT_DELETED;
						res_id_q     <= pid_q;
						state_q      <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid_q   <= 1'b1;
						out_status_q <= res_status_q;
						out_id_q     <= res_id_q;
						out_state_q  <= res_state_q;
						out_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/pst_ram.sv
// Single-port-write, registered-read entry memory.
module pst_ram #(
	parameter int DEPTH  = 32,
	parameter int WIDTH  = 24,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wa,
	input  logic [WIDTH-1:0]  wd,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] ra,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[ra];
		end
	end

	assign rd_data = rd_data_q;

endmodule
